// ----- sv/bpdd_pkg.sv -----
// bpdd_pkg: shared constants, types and controller states for the box pair
// distance / diameter block. No dependencies; compile first.
`default_nettype none
package bpdd_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIGIT_BITS = 4;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int MUL_STEPS  = COORD_BITS / DIGIT_BITS;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int ROOT_STEPS = COORD_BITS;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [SQ_BITS-1:0]           sq_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROOT,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ----- sv/bpdd_in_if.sv -----
// bpdd_in_if: input channel, one axis of a box pair per beat.
// Depends on bpdd_pkg.
`default_nettype none
interface bpdd_in_if;
  logic                valid;
  logic                ready;
  bpdd_pkg::coord_t    box_a_low;
  bpdd_pkg::coord_t    box_a_high;
  bpdd_pkg::coord_t    box_b_low;
  bpdd_pkg::coord_t    box_b_high;
  logic                last_axis;

  modport source (output valid, box_a_low, box_a_high, box_b_low, box_b_high,
                  last_axis, input ready);
  modport sink   (input valid, box_a_low, box_a_high, box_b_low, box_b_high,
                  last_axis, output ready);
endinterface
`default_nettype wire

// ----- sv/bpdd_out_if.sv -----
// bpdd_out_if: result channel, one beat per box pair.
// Depends on bpdd_pkg.
`default_nettype none
interface bpdd_out_if;
  logic              valid;
  logic              ready;
  bpdd_pkg::mag_t    diameter_euclid;
  bpdd_pkg::mag_t    distance_euclid;
  bpdd_pkg::mag_t    diameter_max;
  bpdd_pkg::mag_t    distance_max;
  logic              sum_saturated;

  modport source (output valid, diameter_euclid, distance_euclid, diameter_max,
                  distance_max, sum_saturated, input ready);
  modport sink   (input valid, diameter_euclid, distance_euclid, diameter_max,
                  distance_max, sum_saturated, output ready);
endinterface
`default_nettype wire

// ----- sv/bpdd_sqmul.sv -----
// bpdd_sqmul: digit-serial squarer, one multiplier digit per cycle.
// Depends on bpdd_pkg.
`default_nettype none
module bpdd_sqmul (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire bpdd_pkg::mag_t operand,
  output logic                busy,
  output bpdd_pkg::sq_t       square
);
  localparam int T_W = bpdd_pkg::COORD_BITS + bpdd_pkg::DIGIT_BITS;

  bpdd_pkg::mag_t                  mcand;
  bpdd_pkg::sq_t                   prod;
  logic [bpdd_pkg::MUL_CNT_W-1:0]  cnt;
  logic [T_W-1:0]                  t;

  // upper half plus multiplicand times the low digit still in the shift register
  always_comb begin
    t = T_W'(prod[bpdd_pkg::SQ_BITS-1:bpdd_pkg::COORD_BITS])
      + T_W'(mcand) * T_W'(prod[bpdd_pkg::DIGIT_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == bpdd_pkg::MUL_CNT_W'(bpdd_pkg::MUL_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= operand;
      prod  <= {bpdd_pkg::COORD_BITS'(0), operand};
    end else if (busy) begin
      prod <= {t, prod[bpdd_pkg::COORD_BITS-1:bpdd_pkg::DIGIT_BITS]};
    end
  end

  assign square = prod;
endmodule
`default_nettype wire

// ----- sv/bpdd_sqrt.sv -----
// bpdd_sqrt: restoring floor square root, two radicand bits per cycle.
// Depends on bpdd_pkg.
`default_nettype none
module bpdd_sqrt (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bpdd_pkg::sq_t radicand,
  output logic               busy,
  output bpdd_pkg::mag_t     root
);
  localparam int REM_W = bpdd_pkg::COORD_BITS + 2;
  localparam int R4_W  = bpdd_pkg::COORD_BITS + 4;

  bpdd_pkg::sq_t                    rad;
  logic [REM_W-1:0]                 rem;
  logic [bpdd_pkg::ROOT_CNT_W-1:0]  cnt;
  logic [R4_W-1:0]                  r4;
  logic [R4_W-1:0]                  trial;
  logic [R4_W-1:0]                  diff;
  logic                             fits;

  always_comb begin
    r4    = {rem, rad[bpdd_pkg::SQ_BITS-1:bpdd_pkg::SQ_BITS-2]};
    trial = R4_W'({root, 2'b01});
    fits  = (r4 >= trial);
    diff  = r4 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == bpdd_pkg::ROOT_CNT_W'(bpdd_pkg::ROOT_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[bpdd_pkg::SQ_BITS-3:0], 2'b00};
      rem  <= fits ? diff[REM_W-1:0] : r4[REM_W-1:0];
      root <= {root[bpdd_pkg::COORD_BITS-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// ----- sv/box_pair_distance_diameter_top.sv -----
// box_pair_distance_diameter_top: per-axis box pair accumulation with
// Euclidean diameter and distance by floor square root.
// Depends on bpdd_pkg, bpdd_in_if, bpdd_out_if, bpdd_sqmul, bpdd_sqrt.
//
// Usage: one beat on items carries one axis of boxes A and B (signed Q16.16
// bounds) and a last_axis flag. Each axis passes from the accept through the
// 4-bit digit-serial squarers (8 digit steps, one squarer per sum, working side
// by side) and the saturating 64-bit add before items is ready again. An axis
// with last_axis set then runs both 32-step restoring square roots side by
// side and then loads the result register, which drives the beat on results.
// The result register decouples the two sides: while a result waits for the
// receiver, the next pair's axes are taken and summed; only the next result
// load waits for the register to empty. Sums, maxima and the saturation flag
// clear when a result is loaded. rst (synchronous, active high) returns the
// controller to idle, clears the sums, maxima, saturation flag and unit
// counters, and drops results.valid.
`default_nettype none
module box_pair_distance_diameter_top (
  input  wire logic   clk,
  input  wire logic   rst,
  bpdd_in_if.sink     items,
  bpdd_out_if.source  results
);
  localparam int CW = bpdd_pkg::COORD_BITS;

  bpdd_pkg::state_t state, state_next;

  logic              mul_start, acc_en, root_start, load_out;
  logic              out_free;

  logic [CW:0]       ext_w, d1_w, d2_w;
  bpdd_pkg::mag_t    mag_w, gap_w;
  logic              ext_pos_w;

  bpdd_pkg::mag_t    mag_r, gap_r;
  logic              ext_pos_r, last_r;

  bpdd_pkg::sq_t     ext_sq, gap_sq;
  logic              ext_mul_busy, gap_mul_busy;
  bpdd_pkg::sq_t     ext_sum, gap_sum, ext_sum_next, gap_sum_next;
  logic [bpdd_pkg::SQ_BITS:0] ext_add, gap_add;
  bpdd_pkg::mag_t    ext_max, gap_max;
  logic              sat;

  logic              ext_root_busy, gap_root_busy;
  bpdd_pkg::mag_t    ext_root, gap_root;

  logic              out_valid;

  // per-axis extent and gap: differences as CW+1 bit two's complement, results as CW-bit magnitudes
  always_comb begin
    ext_w = {items.box_a_high[CW-1], items.box_a_high}
          - {items.box_a_low[CW-1], items.box_a_low};
    d1_w  = {items.box_b_low[CW-1], items.box_b_low}
          - {items.box_a_high[CW-1], items.box_a_high};
    d2_w  = {items.box_a_low[CW-1], items.box_a_low}
          - {items.box_b_high[CW-1], items.box_b_high};
    mag_w = ext_w[CW] ? CW'(~ext_w + 1'b1) : ext_w[CW-1:0];
    ext_pos_w = !ext_w[CW] && (ext_w != '0);
    if (!d1_w[CW] && (d1_w != '0)) begin
      gap_w = d1_w[CW-1:0];
    end else if (!d2_w[CW] && (d2_w != '0)) begin
      gap_w = d2_w[CW-1:0];
    end else begin
      gap_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      mag_r     <= mag_w;
      gap_r     <= gap_w;
      ext_pos_r <= ext_pos_w;
      last_r    <= items.last_axis;
    end
  end

  bpdd_sqmul u_ext_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (mag_w),
    .busy    (ext_mul_busy),
    .square  (ext_sq)
  );

  bpdd_sqmul u_gap_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (gap_w),
    .busy    (gap_mul_busy),
    .square  (gap_sq)
  );

  // saturating accumulate
  always_comb begin
    ext_add      = {1'b0, ext_sum} + {1'b0, ext_sq};
    gap_add      = {1'b0, gap_sum} + {1'b0, gap_sq};
    ext_sum_next = ext_add[bpdd_pkg::SQ_BITS] ? '1 : ext_add[bpdd_pkg::SQ_BITS-1:0];
    gap_sum_next = gap_add[bpdd_pkg::SQ_BITS] ? '1 : gap_add[bpdd_pkg::SQ_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || load_out) begin
      ext_sum <= '0;
      gap_sum <= '0;
      ext_max <= '0;
      gap_max <= '0;
      sat     <= 1'b0;
    end else if (acc_en) begin
      ext_sum <= ext_sum_next;
      gap_sum <= gap_sum_next;
      if (ext_pos_r && (mag_r > ext_max)) begin
        ext_max <= mag_r;
      end
      if (gap_r > gap_max) begin
        gap_max <= gap_r;
      end
      if (ext_add[bpdd_pkg::SQ_BITS] || gap_add[bpdd_pkg::SQ_BITS]) begin
        sat <= 1'b1;
      end
    end
  end

  bpdd_sqrt u_ext_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (ext_sum_next),
    .busy     (ext_root_busy),
    .root     (ext_root)
  );

  bpdd_sqrt u_gap_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (gap_sum_next),
    .busy     (gap_root_busy),
    .root     (gap_root)
  );

  assign out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpdd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bpdd_pkg::ST_IDLE: begin
        if (items.valid) state_next = bpdd_pkg::ST_MUL;
      end
      bpdd_pkg::ST_MUL: begin
        if (!ext_mul_busy) state_next = bpdd_pkg::ST_ACC;
      end
      bpdd_pkg::ST_ACC: begin
        state_next = last_r ? bpdd_pkg::ST_ROOT : bpdd_pkg::ST_IDLE;
      end
      bpdd_pkg::ST_ROOT: begin
        if (!ext_root_busy) state_next = bpdd_pkg::ST_EMIT;
      end
      bpdd_pkg::ST_EMIT: begin
        if (out_free) state_next = bpdd_pkg::ST_IDLE;
      end
      default: state_next = bpdd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    items.ready = 1'b0;
    mul_start   = 1'b0;
    acc_en      = 1'b0;
    root_start  = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      bpdd_pkg::ST_IDLE: begin
        items.ready = 1'b1;
        mul_start   = items.valid;
      end
      bpdd_pkg::ST_MUL:  ;
      bpdd_pkg::ST_ACC: begin
        acc_en     = 1'b1;
        root_start = last_r;
      end
      bpdd_pkg::ST_ROOT: ;
      bpdd_pkg::ST_EMIT: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.diameter_euclid <= ext_root;
      results.distance_euclid <= gap_root;
      results.diameter_max    <= ext_max;
      results.distance_max    <= gap_max;
      results.sum_saturated   <= sat;
    end
  end

  assign results.valid = out_valid;

  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    ext_mul_busy == gap_mul_busy)
    else $error("squarers out of step");

  a_root_lockstep: assert property (@(posedge clk) disable iff (rst)
    ext_root_busy == gap_root_busy)
    else $error("root units out of step");

  a_sat_pinned: assert property (@(posedge clk) disable iff (rst)
    sat |-> (ext_sum == '1 || gap_sum == '1))
    else $error("saturation flag without a clipped sum");

  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (ext_sum == '0 && gap_sum == '0 && !sat && out_valid))
    else $error("state not cleared after result load");

endmodule
`default_nettype wire
